FILE: sv/pfs_pkg.sv
// pfs_pkg: shared types and constants for the potential field steering block
// sequencer state encoding, register indexes, angle constants, cordic arctangent table
// no dependencies
package pfs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATT_RADIUS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATT_SPREAD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATT_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REACH_TOLERANCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_RATE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_DEADBAND   = 3'd7;

    localparam logic signed [18:0] PI_Q13     = 19'sd25736;
    localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;
    localparam logic signed [33:0] PI_Q29     = 34'sd1686629713;
    localparam logic [30:0]        SPEED_MAX  = 31'h7FFF_FFFF;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_DIST_WAIT,
        ST_CLASS,
        ST_GAIN,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_COMP,
        ST_SQ_FX,
        ST_SQ_FY,
        ST_SUM2,
        ST_LIN_WAIT,
        ST_CORDIC_INIT,
        ST_CORDIC_RUN,
        ST_ROUND,
        ST_WRAP,
        ST_OUT
    } pfs_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } pfs_sqrt_req_t;

    // arctangent of 2^-i in q2.29
    function automatic logic signed [33:0] atan_step(input logic [4:0] i);
        logic signed [33:0] res;
        unique case (i)
            5'd0:    res = 34'sd421657428;
            5'd1:    res = 34'sd248918915;
            5'd2:    res = 34'sd131521918;
            5'd3:    res = 34'sd66762579;
            5'd4:    res = 34'sd33510843;
            5'd5:    res = 34'sd16771758;
            5'd6:    res = 34'sd8387925;
            5'd7:    res = 34'sd4194219;
            5'd8:    res = 34'sd2097141;
            5'd9:    res = 34'sd1048575;
            5'd30,
            5'd31:   res = '0;
            default: res = 34'sd1 <<< (5'd29 - i);
        endcase
        return res;
    endfunction

endpackage

FILE: sv/pfs_isqrt.sv
// pfs_isqrt: iterative 64-bit integer square root, one result bit per cycle
// depends on pfs_pkg for the request struct
module pfs_isqrt
    import pfs_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  pfs_sqrt_req_t req,
    output logic          done,
    output logic [31:0]   root
);

    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [4:0]  k_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] bitv;
    logic [63:0] trial;

    assign bitv  = 64'd1 << (6'd62 - {k_reg, 1'b0});
    assign trial = r_reg + bitv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && k_reg == 5'd31) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            v_reg <= req.operand;
            r_reg <= '0;
            k_reg <= '0;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bitv;
            end else begin
                r_reg <= r_reg >> 1;
            end
            k_reg <= k_reg + 5'd1;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

FILE: sv/potential_field_steering.sv
// Attractive potential field steering. Each pose beat is turned into one result beat, and the
// sequencer holds the finished result in its last state until the previous result has been
// taken on m_ready. The work is done by two passes of the shared bit-serial square root, the
// two direction divisions (init, 30 quotient bits, multiply), which run only when the field is
// not zero, the cordic loop and the wrap step, all under one sequencer that takes no new pose
// until the current one is finished. Configuration writes take effect at once.
// depends on pfs_pkg and pfs_isqrt
module potential_field_steering
    import pfs_pkg::*;
#(
    parameter int CORDIC_ITERS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_pos_x,
    input  logic signed [31:0]    s_pos_y,
    input  logic signed [15:0]    s_heading,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [30:0]           m_linear_speed,
    output logic signed [15:0]    m_angular_speed,
    output logic                  m_goal_reached
);

    localparam int CntW = $clog2(CORDIC_ITERS);

    pfs_state_t state_reg, state_next;

    logic signed [31:0] goal_x_reg, goal_y_reg;
    logic [30:0] att_radius_reg, att_spread_reg, reach_tol_reg;
    logic [16:0] att_gain_reg;
    logic [14:0] max_turn_reg, deadband_reg;

    logic [31:0]        ax_reg, ay_reg;
    logic               sgnx_reg, sgny_reg;
    logic signed [15:0] hd_reg;
    logic [63:0]        a2_reg, b2_reg;
    logic               ovf_reg;
    logic [32:0]        d_reg;
    logic [32:0]        gop_reg;
    logic [30:0]        m_reg;
    logic [30:0]        c_reg;
    logic [32:0]        rem_reg;
    logic [4:0]         div_cnt_reg;
    logic               comp_y_reg;
    logic signed [31:0] held_x_reg, held_y_reg;
    logic [30:0]        lin_reg;
    logic signed [34:0] cx_reg, cy_reg;
    logic signed [33:0] z_reg;
    logic [CntW-1:0]    iter_reg;
    logic signed [18:0] v_reg;

    logic               m_valid_reg;
    logic [30:0]        lin_out_reg;
    logic signed [15:0] ang_out_reg;
    logic               reached_reg;

    pfs_sqrt_req_t sqrt_req;
    logic          sqrt_done;
    logic [31:0]   sqrt_root;

    // shared multiplier
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;

    logic signed [32:0] dx_in, dy_in;
    logic [64:0]        dist_sum;
    logic signed [34:0] d_s, r_s, t_s, s_s, dmr, s_minus_r, s_plus_r;
    logic               near_goal, lin_branch, far_branch;
    logic [31:0]        div_a;
    logic [33:0]        rem2;
    logic               rem_ge;
    logic [31:0]        comp_p;
    logic [31:0]        hx_abs, hy_abs;
    logic signed [34:0] cx_sh, cy_sh;
    logic signed [33:0] atan_v;
    logic signed [33:0] z_rnd;
    logic signed [16:0] err;
    logic signed [16:0] mtr_s, db_s;
    logic signed [16:0] w_val;
    logic               out_free;

    assign dx_in = 33'(goal_x_reg) - 33'(s_pos_x);
    assign dy_in = 33'(goal_y_reg) - 33'(s_pos_y);

    assign hx_abs = held_x_reg[31] ? 32'(-held_x_reg) : 32'(held_x_reg);
    assign hy_abs = held_y_reg[31] ? 32'(-held_y_reg) : 32'(held_y_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_X:  begin mul_a = {1'b0, ax_reg};  mul_b = {1'b0, ax_reg};  end
            ST_SQ_Y:  begin mul_a = {1'b0, ay_reg};  mul_b = {1'b0, ay_reg};  end
            ST_GAIN:  begin mul_a = {16'b0, att_gain_reg}; mul_b = gop_reg; end
            ST_COMP:  begin mul_a = {2'b0, m_reg};   mul_b = {2'b0, c_reg};   end
            ST_SQ_FX: begin mul_a = {1'b0, hx_abs};  mul_b = {1'b0, hx_abs};  end
            ST_SQ_FY: begin mul_a = {1'b0, hy_abs};  mul_b = {1'b0, hy_abs};  end
            default:  begin mul_a = '0;              mul_b = '0;              end
        endcase
    end

    assign mul_p = 66'(mul_a) * 66'(mul_b);

    assign dist_sum = 65'(a2_reg) + 65'(b2_reg);

    always_comb begin
        sqrt_req.start   = 1'b0;
        sqrt_req.operand = '0;
        if (state_reg == ST_SUM) begin
            sqrt_req.start = 1'b1;
            // sum past 64 bits: root of a quarter, doubled afterwards
            sqrt_req.operand = dist_sum[64] ? {1'b0, dist_sum[64:2]} : dist_sum[63:0];
        end else if (state_reg == ST_SUM2) begin
            sqrt_req.start   = 1'b1;
            sqrt_req.operand = dist_sum[63:0];
        end
    end

    pfs_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // field rule
    assign d_s        = 35'(d_reg);
    assign r_s        = 35'(att_radius_reg);
    assign t_s        = 35'(reach_tol_reg);
    assign s_s        = 35'(att_spread_reg);
    assign dmr        = d_s - r_s;
    assign s_minus_r  = s_s - r_s;
    assign s_plus_r   = s_s + r_s;
    assign near_goal  = dmr < t_s;
    assign lin_branch = (r_s < d_s) && (d_s < s_minus_r);
    assign far_branch = d_s > s_plus_r;

    // direction cosine division, one quotient bit a cycle
    assign div_a  = comp_y_reg ? ay_reg : ax_reg;
    assign rem2   = {rem_reg, 1'b0};
    assign rem_ge = rem2 >= {1'b0, d_reg};
    assign comp_p = mul_p[61:30];

    assign cx_sh  = cx_reg >>> iter_reg;
    assign cy_sh  = cy_reg >>> iter_reg;
    assign atan_v = atan_step(5'(iter_reg));
    assign z_rnd  = z_reg + 34'sd32768;

    assign err   = 17'(v_reg - PI_Q13);
    assign mtr_s = 17'(max_turn_reg);
    assign db_s  = 17'(deadband_reg);

    always_comb begin
        if (!err[16]) begin
            if (err > mtr_s)     w_val = mtr_s;
            else if (err < db_s) w_val = '0;
            else                 w_val = err;
        end else begin
            if (err < -mtr_s)     w_val = -mtr_s;
            else if (err > -db_s) w_val = '0;
            else                  w_val = err;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) state_next = ST_SQ_X;
            end
            ST_SQ_X:      state_next = ST_SQ_Y;
            ST_SQ_Y:      state_next = ST_SUM;
            ST_SUM:       state_next = ST_DIST_WAIT;
            ST_DIST_WAIT: if (sqrt_done) state_next = ST_CLASS;
            ST_CLASS: begin
                if (!near_goal && (lin_branch || far_branch) && d_reg != '0)
                    state_next = ST_GAIN;
                else
                    state_next = ST_SQ_FX;
            end
            ST_GAIN:      state_next = ST_DIV_INIT;
            ST_DIV_INIT:  state_next = ({1'b0, div_a} >= d_reg) ? ST_COMP : ST_DIV_RUN;
            ST_DIV_RUN:   if (div_cnt_reg == 5'd29) state_next = ST_COMP;
            ST_COMP:      state_next = comp_y_reg ? ST_SQ_FX : ST_DIV_INIT;
            ST_SQ_FX:     state_next = ST_SQ_FY;
            ST_SQ_FY:     state_next = ST_SUM2;
            ST_SUM2:      state_next = ST_LIN_WAIT;
            ST_LIN_WAIT:  if (sqrt_done) state_next = ST_CORDIC_INIT;
            ST_CORDIC_INIT: begin
                if (held_x_reg == '0 && held_y_reg == '0) state_next = ST_ROUND;
                else                                      state_next = ST_CORDIC_RUN;
            end
            ST_CORDIC_RUN: if (iter_reg == CntW'(CORDIC_ITERS - 1)) state_next = ST_ROUND;
            ST_ROUND:     state_next = ST_WRAP;
            ST_WRAP: begin
                if (!v_reg[18] && v_reg < TWO_PI_Q13) state_next = ST_OUT;
            end
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // configuration and held field
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            att_radius_reg <= 31'd655;
            att_spread_reg <= 31'd229376;
            att_gain_reg   <= 17'd3277;
            reach_tol_reg  <= 31'd3277;
            max_turn_reg   <= 15'd4096;
            deadband_reg   <= 15'd410;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GOAL_X:          goal_x_reg     <= cfg_wr_data;
                REG_GOAL_Y:          goal_y_reg     <= cfg_wr_data;
                REG_ATT_RADIUS:      att_radius_reg <= cfg_wr_data[30:0];
                REG_ATT_SPREAD:      att_spread_reg <= cfg_wr_data[30:0];
                REG_ATT_GAIN:        att_gain_reg   <= cfg_wr_data[16:0];
                REG_REACH_TOLERANCE: reach_tol_reg  <= cfg_wr_data[30:0];
                REG_MAX_TURN_RATE:   max_turn_reg   <= cfg_wr_data[14:0];
                REG_TURN_DEADBAND:   deadband_reg   <= cfg_wr_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_x_reg <= '0;
            held_y_reg <= '0;
        end else if (state_reg == ST_CLASS && near_goal) begin
            held_x_reg <= '0;
            held_y_reg <= '0;
        end else if (state_reg == ST_COMP) begin
            if (comp_y_reg) held_y_reg <= sgny_reg ? 32'(-comp_p) : comp_p;
            else            held_x_reg <= sgnx_reg ? 32'(-comp_p) : comp_p;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                ax_reg   <= dx_in[32] ? 32'(-dx_in) : dx_in[31:0];
                ay_reg   <= dy_in[32] ? 32'(-dy_in) : dy_in[31:0];
                sgnx_reg <= dx_in[32];
                sgny_reg <= dy_in[32];
                hd_reg   <= s_heading;
            end
            ST_SQ_X:  a2_reg  <= mul_p[63:0];
            ST_SQ_Y:  b2_reg  <= mul_p[63:0];
            ST_SUM:   ovf_reg <= dist_sum[64];
            ST_DIST_WAIT: begin
                if (sqrt_done) d_reg <= ovf_reg ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
            end
            ST_CLASS: begin
                if (lin_branch) gop_reg <= dmr[32:0];
                else            gop_reg <= {2'b0, att_spread_reg};
            end
            ST_GAIN: begin
                m_reg      <= (mul_p[65:47] != '0) ? SPEED_MAX : mul_p[46:16];
                comp_y_reg <= 1'b0;
            end
            ST_DIV_INIT: begin
                rem_reg     <= {1'b0, div_a};
                c_reg       <= ({1'b0, div_a} < d_reg) ? 31'd0 : (31'd1 << 30);
                div_cnt_reg <= '0;
            end
            ST_DIV_RUN: begin
                rem_reg     <= rem_ge ? 33'(rem2 - {1'b0, d_reg}) : rem2[32:0];
                c_reg       <= {c_reg[29:0], rem_ge};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            ST_COMP:  comp_y_reg <= 1'b1;
            ST_SQ_FX: a2_reg <= mul_p[63:0];
            ST_SQ_FY: b2_reg <= mul_p[63:0];
            ST_LIN_WAIT: begin
                if (sqrt_done) lin_reg <= sqrt_root[31] ? SPEED_MAX : sqrt_root[30:0];
            end
            ST_CORDIC_INIT: begin
                iter_reg <= '0;
                if (held_x_reg == '0 && held_y_reg == '0) begin
                    z_reg <= '0;
                end else if (held_x_reg[31]) begin
                    // left half plane: rotate by pi first
                    cx_reg <= -35'(held_x_reg);
                    cy_reg <= -35'(held_y_reg);
                    z_reg  <= held_y_reg[31] ? -PI_Q29 : PI_Q29;
                end else begin
                    cx_reg <= 35'(held_x_reg);
                    cy_reg <= 35'(held_y_reg);
                    z_reg  <= '0;
                end
            end
            ST_CORDIC_RUN: begin
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    z_reg  <= z_reg + atan_v;
                end else begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    z_reg  <= z_reg - atan_v;
                end
                iter_reg <= iter_reg + CntW'(1);
            end
            ST_ROUND: v_reg <= 19'(z_rnd >>> 16) - 19'(hd_reg) + PI_Q13;
            ST_WRAP: begin
                if (v_reg[18])                v_reg <= v_reg + TWO_PI_Q13;
                else if (v_reg >= TWO_PI_Q13) v_reg <= v_reg - TWO_PI_Q13;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            lin_out_reg <= lin_reg;
            ang_out_reg <= w_val[15:0];
            reached_reg <= (lin_reg == '0) && (w_val == '0);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_linear_speed  = lin_out_reg;
    assign m_angular_speed = ang_out_reg;
    assign m_goal_reached  = reached_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a pose beat while busy");

    a_reached_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_goal_reached == (m_linear_speed == '0 && m_angular_speed == '0))
        else $error("goal flag disagrees with speeds");

    a_turn_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (17'(m_angular_speed) <= mtr_s) && (17'(m_angular_speed) >= -mtr_s))
        else $error("angular speed beyond clamp");

    a_sqrt_done_place: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> (state_reg == ST_DIST_WAIT || state_reg == ST_LIN_WAIT))
        else $error("square root finished outside a wait state");

endmodule
